// ===== src/bresenham_line_pixel_generator_macros.svh =====
// Assertion macros for the line pixel generator.
// Used by bresenham_line_pixel_generator.sv; no other dependencies.
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_MACROS_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define BLPG_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BLPG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/blpg_pkg.sv =====
// Shared types and constants of the line pixel generator.
// No dependencies.
package blpg_pkg;

    localparam int REG_BITS    = 7;   // frame size registers
    localparam int ADDR_BITS   = 14;  // byte address of a pixel
    localparam int COLOUR_BITS = 8;

    localparam logic [6:0] FRAME_DIM_RESET = 7'd64;

    // configuration register indexes
    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_ERROR
    } state_t;

endpackage

// ===== src/bresenham_line_pixel_generator.sv =====
// Line pixel generator: Bresenham walk on the major axis, one pixel per cycle if not stalled.
// Depends on blpg_pkg and bresenham_line_pixel_generator_macros.svh.
//
//  channel | ports                       | carries
//  --------+-----------------------------+----------------------------------------
//  in      | s_tvalid s_tready s_tdata   | one line request (endpoints, colour)
//  out     | m_tvalid m_tready m_tdata   | one pixel write; m_tlast on final pixel,
//          | m_tlast m_tuser             | m_tuser = range error
//  cfg     | cfg_wr_en cfg_index         | frame width (0) / frame height (1)
//          | cfg_wdata                   |
//
// A line with major span D passes accept and setup, then D + 1 pixel items;
// the walker emits one pixel per cycle unless m_tready stalls it, paced by the single output register.
// An out-of-frame request takes accept + setup + one error item.
// The next request is accepted once the final item of the line is in the output register.
// aresetn is synchronous; it clears control state and sets both frame registers to 64.
// While m_tready is low and the output register is full, the walker holds.
`include "bresenham_line_pixel_generator_macros.svh"

module bresenham_line_pixel_generator
    import blpg_pkg::*;
#(
    parameter int COORD_BITS = 6
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // s_tdata: start_x, start_y, end_x, end_y, colour_red, colour_green, colour_blue
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [((4*COORD_BITS+24+7)/8)*8-1:0] s_tdata,
    // m_tdata: pixel_x, pixel_y, byte_address, out_red, out_green, out_blue
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [((2*COORD_BITS+38+7)/8)*8-1:0] m_tdata,
    output logic                         m_tlast,
    // m_tuser: range_error
    output logic                         m_tuser,
    input  logic                         cfg_wr_en,
    input  logic [0:0]                   cfg_index,
    input  logic [REG_BITS-1:0]          cfg_wdata
);

    localparam int C      = COORD_BITS;
    localparam int OUT_W  = ((2*C+38+7)/8)*8;
    localparam int EXT_W  = (REG_BITS > C+1) ? REG_BITS : C+1;
    localparam int DW     = C + 3;                      // signed decision width
    localparam int MUL_W  = 2*C + 1;
    localparam int SUM_W  = ((MUL_W > ADDR_BITS) ? MUL_W : ADDR_BITS) + 2;
    localparam logic [EXT_W-1:0] SPAN = EXT_W'(1) << C;

    // ---------------- registers ----------------
    state_t                  state_reg, state_next;
    logic [REG_BITS-1:0]     frame_w_reg, frame_h_reg;
    logic [C-1:0]            x1_reg, y1_reg, x2_reg, y2_reg;
    logic [C-1:0]            x1_next, y1_next, x2_next, y2_next;
    logic [23:0]             colour_reg, colour_next;
    logic [C-1:0]            walk_major_reg, walk_major_next;
    logic [C-1:0]            walk_minor_reg, walk_minor_next;
    logic [C-1:0]            major_end_reg, major_end_next;
    logic signed [DW-1:0]    decision_reg, decision_next;
    logic [C-1:0]            delta_major_reg, delta_major_next;
    logic [C-1:0]            delta_minor_reg, delta_minor_next;
    logic                    minor_neg_reg, minor_neg_next;
    logic                    x_major_reg, x_major_next;

    logic                    out_valid_reg, out_valid_next;
    logic [C-1:0]            out_x_reg, out_x_next;
    logic [C-1:0]            out_y_reg, out_y_next;
    logic [ADDR_BITS-1:0]    out_addr_reg, out_addr_next;
    logic [23:0]             out_colour_reg, out_colour_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_err_reg, out_err_next;

    // ---------------- control strobes ----------------
    logic in_accept;
    logic out_free;
    logic load_pixel;
    logic load_error;

    // ---------------- frame size, clamped ----------------
    logic [EXT_W-1:0] w_ext, h_ext, w_clamp, h_clamp;
    logic [C:0]       frame_w, frame_h;

    assign w_ext   = EXT_W'(frame_w_reg);
    assign h_ext   = EXT_W'(frame_h_reg);
    assign w_clamp = (w_ext > SPAN) ? SPAN : w_ext;
    assign h_clamp = (h_ext > SPAN) ? SPAN : h_ext;
    assign frame_w = w_clamp[C:0];
    assign frame_h = h_clamp[C:0];

    // ---------------- setup arithmetic ----------------
    logic         out_of_frame;
    logic [C-1:0] adx, ady;
    logic         x_major;
    logic [C-1:0] a1, b1, a2, b2, sa1, sb1, sa2, sb2;
    logic         minor_neg;
    logic [C-1:0] dmaj, dmin;

    always_comb begin
        out_of_frame = ({1'b0, x1_reg} >= frame_w) || ({1'b0, x2_reg} >= frame_w) ||
                       ({1'b0, y1_reg} >= frame_h) || ({1'b0, y2_reg} >= frame_h);
        adx     = (x2_reg > x1_reg) ? x2_reg - x1_reg : x1_reg - x2_reg;
        ady     = (y2_reg > y1_reg) ? y2_reg - y1_reg : y1_reg - y2_reg;
        x_major = adx > ady;
        a1 = x_major ? x1_reg : y1_reg;
        b1 = x_major ? y1_reg : x1_reg;
        a2 = x_major ? x2_reg : y2_reg;
        b2 = x_major ? y2_reg : x2_reg;
        // order so the major coordinate rises
        sa1 = (a1 > a2) ? a2 : a1;
        sb1 = (a1 > a2) ? b2 : b1;
        sa2 = (a1 > a2) ? a1 : a2;
        sb2 = (a1 > a2) ? b1 : b2;
        dmaj      = sa2 - sa1;
        minor_neg = sb2 < sb1;
        dmin      = minor_neg ? sb1 - sb2 : sb2 - sb1;
    end

    // ---------------- pixel datapath (shared per step) ----------------
    logic [C-1:0]         px, py;
    logic                 last_step;
    logic [MUL_W-1:0]     row_prod;
    logic [SUM_W-1:0]     lin_index, byte_offs;
    logic signed [DW-1:0] two_dmin, two_dmaj, decision_upd;
    logic                 minor_step;

    always_comb begin
        px        = x_major_reg ? walk_major_reg : walk_minor_reg;
        py        = x_major_reg ? walk_minor_reg : walk_major_reg;
        last_step = walk_major_reg >= major_end_reg;
        row_prod  = MUL_W'(py) * MUL_W'(frame_w);
        lin_index = SUM_W'(row_prod) + SUM_W'(px);
        byte_offs = (lin_index << 1) + lin_index;
        two_dmin  = DW'({delta_minor_reg, 1'b0});
        two_dmaj  = DW'({delta_major_reg, 1'b0});
        minor_step   = decision_reg > 0;
        decision_upd = decision_reg + two_dmin - (minor_step ? two_dmaj : DW'(0));
    end

    // ---------------- sequencer: next state ----------------
    assign out_free  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_SETUP;
            ST_SETUP: state_next = out_of_frame ? ST_ERROR : ST_RUN;
            ST_RUN:   if (out_free && last_step) state_next = ST_IDLE;
            ST_ERROR: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        s_tready   = 1'b0;
        load_pixel = 1'b0;
        load_error = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_tready   = 1'b1;
            ST_SETUP: ;
            ST_RUN:   load_pixel = out_free;
            ST_ERROR: load_error = out_free;
            default:  ;
        endcase
    end

    // ---------------- next values ----------------
    always_comb begin
        x1_next          = x1_reg;
        y1_next          = y1_reg;
        x2_next          = x2_reg;
        y2_next          = y2_reg;
        colour_next      = colour_reg;
        walk_major_next  = walk_major_reg;
        walk_minor_next  = walk_minor_reg;
        major_end_next   = major_end_reg;
        decision_next    = decision_reg;
        delta_major_next = delta_major_reg;
        delta_minor_next = delta_minor_reg;
        minor_neg_next   = minor_neg_reg;
        x_major_next     = x_major_reg;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_addr_next    = out_addr_reg;
        out_colour_next  = out_colour_reg;
        out_last_next    = out_last_reg;
        out_err_next     = out_err_reg;
        out_valid_next   = out_valid_reg && !m_tready;

        if (in_accept) begin
            x1_next     = s_tdata[C-1:0];
            y1_next     = s_tdata[2*C-1:C];
            x2_next     = s_tdata[3*C-1:2*C];
            y2_next     = s_tdata[4*C-1:3*C];
            colour_next = {s_tdata[4*C+7:4*C], s_tdata[4*C+15:4*C+8],
                           s_tdata[4*C+23:4*C+16]};
        end

        if (state_reg == ST_SETUP) begin
            x_major_next     = x_major;
            walk_major_next  = sa1;
            walk_minor_next  = sb1;
            major_end_next   = sa2;
            delta_major_next = dmaj;
            delta_minor_next = dmin;
            minor_neg_next   = minor_neg;
            decision_next    = DW'({dmin, 1'b0}) - DW'(dmaj);
        end

        if (load_pixel) begin
            out_valid_next  = 1'b1;
            out_x_next      = px;
            out_y_next      = py;
            out_addr_next   = byte_offs[ADDR_BITS-1:0];
            out_colour_next = colour_reg;
            out_last_next   = last_step;
            out_err_next    = 1'b0;
            decision_next   = decision_upd;
            if (minor_step) begin
                walk_minor_next = minor_neg_reg ? walk_minor_reg - 1'b1
                                                : walk_minor_reg + 1'b1;
            end
            if (!last_step) walk_major_next = walk_major_reg + 1'b1;
        end

        if (load_error) begin
            out_valid_next  = 1'b1;
            out_x_next      = '0;
            out_y_next      = '0;
            out_addr_next   = '0;
            out_colour_next = '0;
            out_last_next   = 1'b1;
            out_err_next    = 1'b1;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            frame_w_reg     <= FRAME_DIM_RESET;
            frame_h_reg     <= FRAME_DIM_RESET;
            walk_major_reg  <= '0;
            walk_minor_reg  <= '0;
            major_end_reg   <= '0;
            decision_reg    <= '0;
            delta_major_reg <= '0;
            delta_minor_reg <= '0;
            minor_neg_reg   <= 1'b0;
            x_major_reg     <= 1'b0;
            colour_reg      <= '0;
        end else begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            walk_major_reg  <= walk_major_next;
            walk_minor_reg  <= walk_minor_next;
            major_end_reg   <= major_end_next;
            decision_reg    <= decision_next;
            delta_major_reg <= delta_major_next;
            delta_minor_reg <= delta_minor_next;
            minor_neg_reg   <= minor_neg_next;
            x_major_reg     <= x_major_next;
            colour_reg      <= colour_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  frame_w_reg <= cfg_wdata;
                    REG_FRAME_HEIGHT: frame_h_reg <= cfg_wdata;
                    default:          ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        x1_reg         <= x1_next;
        y1_reg         <= y1_next;
        x2_reg         <= x2_next;
        y2_reg         <= y2_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_addr_reg   <= out_addr_next;
        out_colour_reg <= out_colour_next;
        out_last_reg   <= out_last_next;
        out_err_reg    <= out_err_next;
    end

    // ---------------- ports ----------------
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;
    assign m_tdata  = OUT_W'({out_colour_reg[7:0], out_colour_reg[15:8],
                              out_colour_reg[23:16], out_addr_reg, out_y_reg, out_x_reg});

    // ---------------- assertions ----------------
    `BLPG_ASSERT_NOW(a_err_item_clean, aclk, aresetn, m_tvalid && m_tuser, m_tlast && (m_tdata == '0), "range error item not blank or not last")
    `BLPG_ASSERT_NOW(a_mid_line_running, aclk, aresetn, m_tvalid && !m_tuser && !m_tlast, state_reg == ST_RUN, "non-final pixel while walker not running")
    `BLPG_ASSERT_NOW(a_walk_in_bounds, aclk, aresetn, state_reg == ST_RUN, walk_major_reg <= major_end_reg, "major walk passed line end")
    `BLPG_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request taken while line in progress")

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for bresenham_line_pixel_generator: random and directed line requests,
// a Bresenham predictor that builds the expected pixel items, and random idling on both streams.
// Depends on blpg_pkg and the generator RTL.
`timescale 1ns / 1ps

module tb_top;
    import blpg_pkg::*;

    localparam int COORD_BITS = 6;
    localparam int COORD_SPAN = 1 << COORD_BITS;
    localparam int COORD_MASK = COORD_SPAN - 1;

    // packed from the top bit down, so start_x lands in s_tdata[5:0]
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [5:0] end_y;
        logic [5:0] end_x;
        logic [5:0] start_y;
        logic [5:0] start_x;
    } line_t;

    typedef struct packed {
        logic [5:0]  pixel_x;
        logic [5:0]  pixel_y;
        logic [13:0] byte_addr;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last_pixel;
        logic        range_err;
    } pixel_write_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // start_x, start_y, end_x, end_y, red, green, blue
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;        // pixel_x, pixel_y, byte_address, red, green, blue
    logic        m_tlast;
    logic        m_tuser;        // range_error
    logic        cfg_wr_en;
    logic [0:0]  cfg_index;
    logic [REG_BITS-1:0] cfg_wdata;

    bresenham_line_pixel_generator #(.COORD_BITS(COORD_BITS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    line_t        line_queue[$];
    pixel_write_t pixel_queue[$];

    logic [6:0] frame_w = FRAME_DIM_RESET;
    logic [6:0] frame_h = FRAME_DIM_RESET;

    int  error_count   = 0;
    bit  bursts_on     = 1'b1;
    bit  stall_request = 1'b0;
    bit  stall_done    = 1'b0;
    bit  line_taken    = 1'b0;
    int  src_gap       = 0;
    int  rx_gap        = 0;
    int  long_hold     = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // expected pixel items for one accepted line request
    task automatic draw_line(line_t req);
        int w, h, sx, sy, ex, ey, adx, ady, a1, b1, a2, b2, tmp;
        int d_major, d_minor, decision, walk_major, walk_minor;
        bit x_major, step_neg, done;
        pixel_write_t p;
        w  = (int'(frame_w) > COORD_SPAN) ? COORD_SPAN : int'(frame_w);
        h  = (int'(frame_h) > COORD_SPAN) ? COORD_SPAN : int'(frame_h);
        sx = int'(req.start_x);
        sy = int'(req.start_y);
        ex = int'(req.end_x);
        ey = int'(req.end_y);
        if (sx >= w || sy >= h || ex >= w || ey >= h) begin
            p = '0;
            p.last_pixel = 1'b1;
            p.range_err  = 1'b1;
            pixel_queue.push_back(p);
            return;
        end
        adx = (ex > sx) ? ex - sx : sx - ex;
        ady = (ey > sy) ? ey - sy : sy - ey;
        x_major = adx > ady;   // ties walk along y
        if (x_major) begin
            a1 = sx; b1 = sy; a2 = ex; b2 = ey;
        end else begin
            a1 = sy; b1 = sx; a2 = ey; b2 = ex;
        end
        if (a1 > a2) begin
            tmp = a1; a1 = a2; a2 = tmp;
            tmp = b1; b1 = b2; b2 = tmp;
        end
        d_major    = a2 - a1;
        step_neg   = b2 < b1;
        d_minor    = step_neg ? b1 - b2 : b2 - b1;
        decision   = 2 * d_minor - d_major;
        walk_major = a1;
        walk_minor = b1;
        done       = 1'b0;
        while (!done) begin
            p.pixel_x    = 6'(x_major ? walk_major : walk_minor);
            p.pixel_y    = 6'(x_major ? walk_minor : walk_major);
            p.byte_addr  = 14'((int'(p.pixel_y) * w + int'(p.pixel_x)) * 3);
            p.red        = req.red;
            p.green      = req.green;
            p.blue       = req.blue;
            p.last_pixel = walk_major >= a2;
            p.range_err  = 1'b0;
            pixel_queue.push_back(p);
            if (decision > 0) begin
                walk_minor = (step_neg ? walk_minor - 1 : walk_minor + 1) & COORD_MASK;
                decision   = decision - 2 * d_major;
            end
            decision = decision + 2 * d_minor;
            if (p.last_pixel)
                done = 1'b1;
            else
                walk_major = (walk_major + 1) & COORD_MASK;
        end
    endtask

    // accept side: record handshakes and predict
    always @(posedge aclk) begin
        line_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            draw_line(line_t'(s_tdata));
    end

    // sender: new item after acceptance, random gaps between items
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || line_taken)) begin
            if (src_gap > 0) begin
                s_tvalid <= 1'b0;
                src_gap = src_gap - 1;
            end else if (line_queue.size() > 0) begin
                s_tdata  <= line_queue.pop_front();
                s_tvalid <= 1'b1;
                if (bursts_on && $urandom_range(0, 3) == 0)
                    src_gap = $urandom_range(1, 5);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random ready bursts plus one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (long_hold > 0) begin
            m_tready <= 1'b0;
            long_hold = long_hold - 1;
        end else if (stall_request && !stall_done) begin
            stall_done = 1'b1;
            long_hold  = 300;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap = rx_gap - 1;
        end else if (bursts_on && $urandom_range(0, 5) == 0) begin
            rx_gap = $urandom_range(1, 5) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor: compare each pixel item with the oldest expectation
    always @(posedge aclk) begin
        pixel_write_t got, want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got.pixel_x    = m_tdata[5:0];
            got.pixel_y    = m_tdata[11:6];
            got.byte_addr  = m_tdata[25:12];
            got.red        = m_tdata[33:26];
            got.green      = m_tdata[41:34];
            got.blue       = m_tdata[49:42];
            got.last_pixel = m_tlast;
            got.range_err  = m_tuser;
            if (pixel_queue.size() == 0) begin
                error_count++;
                $display("%0t: unexpected pixel item x=%0d y=%0d addr=%0d last=%b err=%b",
                         $realtime, got.pixel_x, got.pixel_y, got.byte_addr,
                         got.last_pixel, got.range_err);
            end else begin
                want = pixel_queue.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display("%0t: mismatch exp x=%0d y=%0d addr=%0d rgb=%h%h%h last=%b err=%b",
                             $realtime, want.pixel_x, want.pixel_y, want.byte_addr,
                             want.red, want.green, want.blue, want.last_pixel, want.range_err);
                    $display("%0t:          got x=%0d y=%0d addr=%0d rgb=%h%h%h last=%b err=%b",
                             $realtime, got.pixel_x, got.pixel_y, got.byte_addr,
                             got.red, got.green, got.blue, got.last_pixel, got.range_err);
                end
            end
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [REG_BITS-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        if (idx == REG_FRAME_WIDTH)
            frame_w = value;
        else
            frame_h = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_frame(int w, int h);
        write_reg(REG_FRAME_WIDTH, REG_BITS'(w));
        write_reg(REG_FRAME_HEIGHT, REG_BITS'(h));
    endtask

    task automatic push_line(int sx, int sy, int ex, int ey, logic [23:0] rgb);
        line_t l;
        l.start_x = 6'(sx);
        l.start_y = 6'(sy);
        l.end_x   = 6'(ex);
        l.end_y   = 6'(ey);
        {l.red, l.green, l.blue} = rgb;
        line_queue.push_back(l);
    endtask

    // mostly in-frame endpoints, some anywhere so range errors occur
    task automatic push_random(int count);
        int w, h;
        line_t l;
        w = (int'(frame_w) > COORD_SPAN) ? COORD_SPAN : int'(frame_w);
        h = (int'(frame_h) > COORD_SPAN) ? COORD_SPAN : int'(frame_h);
        repeat (count) begin
            if (w == 0 || h == 0 || $urandom_range(0, 7) == 0) begin
                l.start_x = 6'($urandom_range(0, COORD_MASK));
                l.start_y = 6'($urandom_range(0, COORD_MASK));
                l.end_x   = 6'($urandom_range(0, COORD_MASK));
                l.end_y   = 6'($urandom_range(0, COORD_MASK));
            end else begin
                l.start_x = 6'($urandom_range(0, w - 1));
                l.start_y = 6'($urandom_range(0, h - 1));
                l.end_x   = 6'($urandom_range(0, w - 1));
                l.end_y   = 6'($urandom_range(0, h - 1));
            end
            l.red   = 8'($urandom());
            l.green = 8'($urandom());
            l.blue  = 8'($urandom());
            line_queue.push_back(l);
        end
    endtask

    // wait until every request is taken and every pixel item has arrived
    task automatic drain();
        while (line_queue.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (pixel_queue.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_wdata = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset frame 64x64
        push_line(0, 0, 0, 0, 24'h000000);       // equal endpoints
        push_line(63, 63, 0, 0, 24'hffffff);     // diagonal tie, reversed
        push_line(0, 0, 63, 0, 24'h123456);      // horizontal
        push_line(0, 63, 0, 0, 24'hff00aa);      // vertical, reversed
        push_line(0, 0, 63, 62, 24'h55aa55);
        push_line(63, 0, 0, 63, 24'haa55aa);     // minor axis steps down
        push_line(10, 5, 50, 20, 24'h0f0f0f);
        push_line(5, 60, 20, 2, 24'hf0f0f0);
        push_line(3, 4, 2, 9, 24'h808080);
        push_line(62, 1, 1, 2, 24'h7f7f7f);
        drain();

        set_frame(40, 25);
        push_line(39, 24, 0, 0, 24'hc0ffee);
        push_line(40, 0, 0, 0, 24'hffffff);      // x out of frame
        push_line(0, 0, 0, 25, 24'hffffff);      // y out of frame
        push_line(0, 24, 39, 0, 24'h010203);
        push_random(10);
        drain();

        set_frame(1, 1);
        push_line(0, 0, 0, 0, 24'habcdef);
        push_line(1, 0, 0, 0, 24'habcdef);
        push_random(5);
        drain();

        set_frame(127, 100);                    // oversized, used as 64
        push_line(0, 63, 63, 63, 24'h314159);
        push_random(10);
        drain();

        set_frame(0, 64);                       // zero width
        push_line(0, 0, 0, 0, 24'hffffff);
        push_random(4);
        drain();

        set_frame(64, 0);                       // zero height
        push_random(3);
        drain();

        set_frame(64, 64);
        stall_request = 1'b1;
        push_random(50);
        drain();

        // closing stretch without idling
        set_frame(23, 64);
        bursts_on = 1'b0;
        push_random(20);
        drain();

        repeat (10) @(posedge aclk);
        if (error_count == 0 && pixel_queue.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
